// File: hw/rtl/cblm_pkg.sv
// ----------------------------------------------------------------------------
// Character box line merger package
// Shared widths, constants and types of the line merger.
// ----------------------------------------------------------------------------
package cblm_pkg;

  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned MaxRunDef    = 1024;

  // Command to the divider: one mean request.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Status back from the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: hw/rtl/cblm_if.sv
// ----------------------------------------------------------------------------
// Box stream interface
// Valid/ready channel that carries one box per beat.
// ----------------------------------------------------------------------------
interface cblm_if #(
  parameter int unsigned W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left;
  logic signed [W-1:0] top;
  logic signed [W-1:0] right;
  logic signed [W-1:0] bottom;
  logic                last;

  modport source (output valid, left, top, right, bottom, last, input ready);
  modport sink   (input valid, left, top, right, bottom, last, output ready);
endinterface

// File: hw/rtl/cblm_mean_div.sv
// ----------------------------------------------------------------------------
// Mean divider
// Rounded mean of a signed sum over a member count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cblm_mean_div
  import cblm_pkg::*;
#(
  parameter int unsigned SW = 35,
  parameter int unsigned NW = 11,
  parameter int unsigned CW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctl_t             ctl_i,
  input  logic signed [SW-1:0] sum_i,
  input  logic        [NW-1:0] cnt_i,
  output div_sts_t             sts_o,
  output logic signed [CW-1:0] mean_o
);
  // Floor((2*sum + n) / (2n)). The numerator is biased positive by a multiple
  // of the divisor so that an unsigned restoring divide gives the floor.
  localparam int unsigned AW = SW + NW + 3;
  localparam int unsigned CntW = $clog2(AW + 1);

  logic [AW-1:0]   rem_q, rem_d, quo_q, quo_d, num;
  logic [AW-1:0]   div_q, div_d;
  logic [AW-1:0]   bias_q, bias_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [AW-1:0]   trial;
  logic [AW-1:0]   quo_fix;

  always_comb begin
    num = (AW'(signed'(sum_i)) << 1) + AW'(cnt_i) + (AW'(cnt_i) << (SW + 1));
  end

  assign trial   = {rem_q[AW-2:0], quo_q[AW-1]};
  assign quo_fix = quo_q - bias_q;

  // Restoring shift-subtract step.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    bias_d = bias_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d  = '0;
      quo_d  = num;
      div_d  = AW'(cnt_i) << 1;
      bias_d = AW'(1) << SW;
      cnt_d  = CntW'(AW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= div_q) begin
        rem_d = trial - div_q;
        quo_d = {quo_q[AW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[AW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    bias_q <= bias_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign mean_o     = quo_fix[CW-1:0];
endmodule

// File: hw/rtl/char_box_line_merger_unit.sv
// ----------------------------------------------------------------------------
// Character box line merger
// Groups character boxes into line boxes and holds one line box for clipping.
//
//   channel   dir  beat
//   in_box    in   one character box, last marks end of selection
//   out_box   out  one line box, last marks final line box
//
// A box that joins or opens a group keeps the input busy while the sequencer
// passes through decide, start, flush and out. Closing a group runs two serial
// divisions (top then bottom mean) of SW+NW+3 quotient bits. An end of
// selection adds one more close. Each result waits in the output register until
// taken; the input stalls meanwhile. Reset is asynchronous and clears all group
// and held-box state.
// ----------------------------------------------------------------------------
module char_box_line_merger_unit
  import cblm_pkg::*;
#(
  parameter int unsigned MAX_RUN    = MaxRunDef,
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input logic  clk_i,
  input logic  rst_ni,
  cblm_if.sink   in_box,
  cblm_if.source out_box
);
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned NW = $clog2(MAX_RUN + 1);
  localparam int unsigned SW = CW + NW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DIVT   = 4'd2;
  localparam logic [3:0] S_WAITT  = 4'd3;
  localparam logic [3:0] S_DIVB   = 4'd4;
  localparam logic [3:0] S_WAITB  = 4'd5;
  localparam logic [3:0] S_CLIP   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_START  = 4'd8;
  localparam logic [3:0] S_FLUSH  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] st_q, st_d;

  // Captured input beat.
  logic signed [CW-1:0] cl_q, ct_q, cr_q, cb_q;
  logic                 clast_q;
  // Previous character box and open group.
  logic signed [CW-1:0] pl_q, pt_q, pr_q, pb_q;
  logic signed [CW-1:0] gl_q, gr_q;
  logic signed [SW-1:0] st_sum_q, sb_sum_q;
  logic        [NW-1:0] gcnt_q;
  // Line box being closed and the held box.
  logic signed [CW-1:0] lt_q, lb_q;
  logic signed [CW-1:0] hl_q, ht_q, hr_q, hb_q;
  logic                 hv_q;
  // Which close is running: 0 for a break, 1 for end of selection.
  logic                 fl_q;
  // Output register.
  logic                 ov_q;
  logic signed [CW-1:0] ol_q, ot_q, or_q, ob_q;
  logic                 olast_q;

  div_ctl_t             dctl;
  div_sts_t             dsts;
  logic signed [SW-1:0] dsum;
  logic signed [CW-1:0] dmean;

  assign dsum = (st_q == S_DIVB) ? sb_sum_q : st_sum_q;

  cblm_mean_div #(.SW(SW), .NW(NW), .CW(CW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .sum_i  (dsum),
    .cnt_i  (gcnt_q),
    .sts_o  (dsts),
    .mean_o (dmean)
  );

  // Join test, evaluated combinationally in the decide state.
  localparam int unsigned JW = CW + 4;
  logic signed [JW-1:0] xd, y1, y2, yd, ws, hs;
  logic                 join_ok;
  function automatic logic signed [JW-1:0] mag(input logic signed [JW-1:0] v);
    mag = v[JW-1] ? -v : v;
  endfunction
  always_comb begin
    xd = mag(JW'(pr_q) - JW'(cr_q));
    y1 = mag(JW'(pt_q) - JW'(ct_q));
    y2 = mag(JW'(pb_q) - JW'(cb_q));
    yd = (y1 < y2) ? y1 : y2;
    ws = (JW'(pr_q) - JW'(pl_q)) + (JW'(cr_q) - JW'(cl_q));
    hs = (JW'(pb_q) - JW'(pt_q)) + (JW'(cb_q) - JW'(ct_q));
    join_ok = ((xd <<< 1) < (ws + (ws <<< 1))) && (yd < hs);
  end

  // Clip test of the new line box against the held box.
  logic signed [JW-1:0] hh, dt;
  logic                 clip;
  always_comb begin
    hh   = mag(JW'(hb_q) - JW'(ht_q));
    dt   = mag(JW'(lt_q) - JW'(ht_q));
    clip = !((dt <<< 1) < hh) && (gl_q < hr_q);
  end

  assign in_box.ready  = (st_q == S_IDLE);
  assign out_box.valid = ov_q;
  assign out_box.left  = ol_q;
  assign out_box.top   = ot_q;
  assign out_box.right = or_q;
  assign out_box.bottom = ob_q;
  assign out_box.last  = olast_q;

  assign dctl.start = (st_q == S_DIVT) || (st_q == S_DIVB);

  // Sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:   if (in_box.valid) st_d = S_DECIDE;
      S_DECIDE: begin
        if (gcnt_q == '0) st_d = S_START;
        else if (gcnt_q < NW'(MAX_RUN) && join_ok) st_d = S_START;
        else st_d = S_DIVT;
      end
      S_DIVT:  st_d = S_WAITT;
      S_WAITT: if (dsts.done) st_d = S_DIVB;
      S_DIVB:  st_d = S_WAITB;
      S_WAITB: if (dsts.done) st_d = S_CLIP;
      S_CLIP:  st_d = S_EMIT;
      S_EMIT:  if (!ov_q) st_d = fl_q ? S_OUT : S_START;
      // A group is always open once this state has run.
      S_START: st_d = clast_q ? S_DIVT : S_FLUSH;
      S_FLUSH: st_d = S_OUT;
      S_OUT:   if (!ov_q) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      gcnt_q  <= '0;
      hv_q    <= 1'b0;
      ov_q    <= 1'b0;
      fl_q    <= 1'b0;
      pl_q    <= '0; pt_q <= '0; pr_q <= '0; pb_q <= '0;
      gl_q    <= '0; gr_q <= '0;
      st_sum_q <= '0; sb_sum_q <= '0;
      hl_q    <= '0; ht_q <= '0; hr_q <= '0; hb_q <= '0;
      lt_q    <= '0; lb_q <= '0;
      ol_q    <= '0; ot_q <= '0; or_q <= '0; ob_q <= '0;
      olast_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_q && out_box.ready) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: fl_q <= 1'b0;
        S_DECIDE: begin
          // Join in place; otherwise fall to start or close.
          if (gcnt_q != '0 && gcnt_q < NW'(MAX_RUN) && join_ok) begin
            if (cl_q < gl_q) gl_q <= cl_q;
            if (cr_q > gr_q) gr_q <= cr_q;
            st_sum_q <= st_sum_q + SW'(ct_q);
            sb_sum_q <= sb_sum_q + SW'(cb_q);
            gcnt_q   <= gcnt_q + NW'(1);
            pl_q <= cl_q; pt_q <= ct_q; pr_q <= cr_q; pb_q <= cb_q;
          end
        end
        S_WAITT: if (dsts.done) lt_q <= dmean;
        S_WAITB: if (dsts.done) lb_q <= dmean;
        S_CLIP:  if (hv_q && clip) lt_q <= hb_q;
        S_EMIT: begin
          if (!ov_q) begin
            if (hv_q) begin
              ov_q <= 1'b1;
              ol_q <= hl_q; ot_q <= ht_q; or_q <= hr_q; ob_q <= hb_q;
              olast_q <= 1'b0;
            end
            hl_q <= gl_q; ht_q <= lt_q; hr_q <= gr_q; hb_q <= lb_q;
            hv_q <= 1'b1;
            gcnt_q <= '0;
          end
        end
        S_START: begin
          // Start a new group unless this pass only follows a join.
          if (gcnt_q == '0) begin
            gl_q <= cl_q; gr_q <= cr_q;
            st_sum_q <= SW'(ct_q); sb_sum_q <= SW'(cb_q);
            gcnt_q <= NW'(1);
            pl_q <= cl_q; pt_q <= ct_q; pr_q <= cr_q; pb_q <= cb_q;
          end
          if (clast_q) fl_q <= 1'b1;
        end
        S_FLUSH: fl_q <= clast_q;
        S_OUT: begin
          if (!ov_q) begin
            if (fl_q && hv_q) begin
              ov_q <= 1'b1;
              ol_q <= hl_q; ot_q <= ht_q; or_q <= hr_q; ob_q <= hb_q;
              olast_q <= 1'b1;
            end
            if (fl_q) begin
              hv_q   <= 1'b0;
              gcnt_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (in_box.valid && in_box.ready) begin
      cl_q <= in_box.left; ct_q <= in_box.top;
      cr_q <= in_box.right; cb_q <= in_box.bottom;
      clast_q <= in_box.last;
    end
  end
endmodule

// File: tb/char_box_line_merger_unit_tb.sv
// ----------------------------------------------------------------------------
// Character box line merger testbench
// Drives character boxes through the merger with random idling and stalls,
// predicts the line boxes it should produce and compares each output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module char_box_line_merger_unit_tb;
  import cblm_pkg::*;

  localparam int unsigned CW       = CoordBitsDef;
  localparam int unsigned RUN_MAX  = MaxRunDef;
  localparam int          WDOG_MAX = 20000;
  localparam int          N_RAND   = 290;

  typedef struct packed {
    logic signed [CW-1:0] l;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] b;
    logic                 last;
  } box_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cblm_if #(.W(CW)) in_box ();
  cblm_if #(.W(CW)) out_box ();

  char_box_line_merger_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_box (in_box.sink),
    .out_box(out_box.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  longint    prev_l, prev_t, prev_r, prev_b;
  longint    grp_left, grp_right, top_sum, bot_sum;
  int        grp_cnt;
  longint    held_box[4];
  bit        held_valid;
  box_beat_t line_q[$];
  box_beat_t char_q[$];

  int  err_cnt = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;
  bit  sink_hold = 1'b0;
  bit  src_hold = 1'b0;
  int  drv_gap = 0;
  int  mon_gap = 0;
  int  quiet = 0;
  int  n_lines = 0;

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch on line box %0d: %s got %0d expected %0d", n_lines, what, got, exp);
    err_cnt++;
  endtask

  function automatic longint rounded_mean(input longint sum, input int n);
    longint d, a, q;
    d = 2 * n;
    a = 2 * sum + n;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint absv(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Appends a character box to the stimulus queue.
  function automatic void add_char(input box_beat_t c);
    char_q = {char_q, c};
  endfunction

  function automatic void push_line(input longint bx[4], input bit last);
    box_beat_t e;
    e.l = bx[0]; e.t = bx[1]; e.r = bx[2]; e.b = bx[3]; e.last = last;
    line_q = {line_q, e};
  endfunction

  // A closed group becomes the held box; the previously held one goes out.
  function automatic void close_line();
    longint ln[4];
    longint h;
    bit same_row;
    if (grp_cnt == 0) return;
    ln[0] = grp_left;
    ln[1] = rounded_mean(top_sum, grp_cnt);
    ln[2] = grp_right;
    ln[3] = rounded_mean(bot_sum, grp_cnt);
    grp_cnt = 0;
    if (held_valid) begin
      h = absv(held_box[3] - held_box[1]);
      same_row = 2 * absv(ln[1] - held_box[1]) < h;
      if (!same_row && ln[0] < held_box[2]) ln[1] = held_box[3];
      push_line(held_box, 1'b0);
    end
    held_box = ln;
    held_valid = 1'b1;
  endfunction

  function automatic void open_group(input longint l, t, r, b);
    grp_left = l; grp_right = r; top_sum = t; bot_sum = b; grp_cnt = 1;
    prev_l = l; prev_t = t; prev_r = r; prev_b = b;
  endfunction

  function automatic void predict_lines(input box_beat_t c);
    longint l, t, r, b, xd, yd, y1, y2, ws, hs;
    bit fits;
    l = c.l; t = c.t; r = c.r; b = c.b;
    xd = absv(prev_r - r);
    y1 = absv(prev_t - t);
    y2 = absv(prev_b - b);
    yd = y1 < y2 ? y1 : y2;
    ws = (prev_r - prev_l) + (r - l);
    hs = (prev_b - prev_t) + (b - t);
    fits = (2 * xd < 3 * ws) && (yd < hs);
    if (grp_cnt == 0) begin
      open_group(l, t, r, b);
    end else if (grp_cnt < RUN_MAX && fits) begin
      if (l < grp_left) grp_left = l;
      if (r > grp_right) grp_right = r;
      top_sum += t; bot_sum += b; grp_cnt++;
      prev_l = l; prev_t = t; prev_r = r; prev_b = b;
    end else begin
      close_line();
      open_group(l, t, r, b);
    end
    if (c.last) begin
      close_line();
      if (held_valid) push_line(held_box, 1'b1);
      held_valid = 1'b0;
    end
  endfunction

  function automatic box_beat_t mk_box(input longint l, t, r, b, input bit last);
    box_beat_t x;
    x.l = l; x.t = t; x.r = r; x.b = b; x.last = last;
    return x;
  endfunction

  function automatic box_beat_t rand_box(input bit last);
    return mk_box($signed(CW'($urandom)), $signed(CW'($urandom)),
                  $signed(CW'($urandom)), $signed(CW'($urandom)), last);
  endfunction

  // Plausible text: boxes along rows, with random sizes, row breaks, occasional noise boxes and selection ends.
  task automatic queue_text_run(input int n, inout longint x, inout longint y);
    longint w, h;
    box_beat_t c;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(256, 4096);
      h = $urandom_range(2048, 6000);
      if ($urandom_range(0, 9) == 0) begin
        y += $urandom_range(3000, 12000);
        x = $signed(longint'($urandom_range(0, 40000))) - 20000;
      end
      c = mk_box(x, y + $urandom_range(0, 300), x + w,
                 y + h - $urandom_range(0, 300), 1'b0);
      if ($urandom_range(0, 15) == 0) c = rand_box(1'b0);
      c.last = (i == n - 1) || ($urandom_range(0, 29) == 0);
      add_char(c);
      x += w + $urandom_range(0, 600);
    end
  endtask

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_box.valid  <= 1'b0;
      in_box.left   <= '0;
      in_box.top    <= '0;
      in_box.right  <= '0;
      in_box.bottom <= '0;
      in_box.last   <= 1'b0;
      drv_gap       <= 0;
    end else begin
      if (in_box.valid && in_box.ready) predict_lines(char_q.pop_front());
      if (!in_box.valid || in_box.ready) begin
        if (drv_gap > 0) begin
          drv_gap      <= drv_gap - 1;
          in_box.valid <= 1'b0;
        end else if (char_q.size() != 0 && !src_hold) begin
          // The head of the queue is always the next beat to offer.
          in_box.valid  <= 1'b1;
          in_box.left   <= char_q[0].l;
          in_box.top    <= char_q[0].t;
          in_box.right  <= char_q[0].r;
          in_box.bottom <= char_q[0].b;
          in_box.last   <= char_q[0].last;
          if (!calm && $urandom_range(0, 7) == 0) drv_gap <= $urandom_range(1, 12);
        end else begin
          in_box.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_box.ready <= 1'b0;
      mon_gap       <= 0;
      quiet         <= 0;
    end else begin
      if (out_box.valid && out_box.ready) begin
        if (line_q.size() == 0) begin
          $display("unexpected line box %0d", n_lines);
          err_cnt++;
        end else begin
          box_beat_t e;
          e = line_q.pop_front();
          if (out_box.left != e.l) report_mismatch("left", out_box.left, e.l);
          if (out_box.top != e.t) report_mismatch("top", out_box.top, e.t);
          if (out_box.right != e.r) report_mismatch("right", out_box.right, e.r);
          if (out_box.bottom != e.b) report_mismatch("bottom", out_box.bottom, e.b);
          if (out_box.last != e.last) report_mismatch("last", out_box.last, e.last);
        end
        n_lines++;
      end
      if ((out_box.valid && out_box.ready) || (in_box.valid && in_box.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (sink_hold) begin
        out_box.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap       <= mon_gap - 1;
        out_box.ready <= 1'b0;
      end else begin
        out_box.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) mon_gap <= $urandom_range(1, 12);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (quiet >= WDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    longint x, y;
    grp_cnt = 0; held_valid = 1'b0;
    prev_l = 0; prev_t = 0; prev_r = 0; prev_b = 0;
    grp_left = 0; grp_right = 0; top_sum = 0; bot_sum = 0;
    held_box = '{0, 0, 0, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a row of joining boxes with a second row close enough to join it,
    // a selection end, field extremes, malformed boxes and a lone box.
    add_char(mk_box(0, 0, 2560, 4096, 1'b0));
    add_char(mk_box(2816, 0, 5376, 4096, 1'b0));
    add_char(mk_box(5632, 256, 8192, 4352, 1'b0));
    add_char(mk_box(0, 3840, 2560, 8192, 1'b0));
    add_char(mk_box(2816, 3840, 5376, 8192, 1'b0));
    add_char(mk_box(100000, 50000, 102560, 54096, 1'b1));
    add_char(mk_box(-8388608, -8388608, 8388607, 8388607, 1'b0));
    add_char(mk_box(-8388608, -8388608, 8388607, 8388607, 1'b0));
    add_char(mk_box(8388607, 8388607, -8388608, -8388608, 1'b0));
    add_char(mk_box(-8388608, 8388607, -8388608, 8388607, 1'b0));
    add_char(mk_box(5000, 9000, 1000, 2000, 1'b0));
    add_char(mk_box(-3, -5, -1, -2, 1'b0));
    add_char(mk_box(-4, -6, -1, -1, 1'b1));
    add_char(mk_box(7, 7, 7, 7, 1'b1));
    add_char(mk_box(0, 0, 0, 0, 1'b0));
    add_char(mk_box(-1, -1, -1, -1, 1'b1));

    // Stall the receiver for a long stretch while input keeps coming.
    x = 0; y = 0;
    queue_text_run(20, x, y);
    sink_hold = 1'b1;
    repeat (600) @(posedge clk_i);
    sink_hold = 1'b0;
    wait (char_q.size() == 0);

    // Sender pause until every line box has drained.
    src_hold = 1'b1;
    queue_text_run(1, x, y);
    wait (line_q.size() == 0);
    src_hold = 1'b0;

    // Random part: mostly text-like rows, some noise.
    for (int k = 0; k < N_RAND; ) begin
      int n;
      n = $urandom_range(1, 24);
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < n; i++) add_char(rand_box($urandom_range(0, 5) == 0));
      end else begin
        queue_text_run(n, x, y);
      end
      k += n;
      if (k > N_RAND * 3 / 4) calm = 1'b1;
      wait (char_q.size() < 8);
    end
    wait (char_q.size() == 0 && !in_box.valid);
    wait (line_q.size() == 0);
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
    if (err_cnt == 0 && line_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cblm_pkg.sv
hw/rtl/cblm_if.sv
hw/rtl/cblm_mean_div.sv
hw/rtl/char_box_line_merger_unit.sv
tb/char_box_line_merger_unit_tb.sv
